// ===== hw/rtl/trfw_pkg.sv =====
// Package for the transmit ring frame writer.
// Holds widths, status codes, state types and length helpers.
// No dependencies; used by all files in hw/rtl.
package trfw_pkg;

    localparam int PTR_BITS      = 26;
    localparam int LEN_BITS      = 11;
    localparam int ALEN_BITS     = 12;
    localparam int LOG2_BITS     = 5;
    localparam int LOG2_MIN      = 11;
    localparam int MAX_FRAME     = 1514;
    localparam int MIN_FRAME     = 60;
    localparam int RESULT_LIMIT  = 16;
    localparam int CNT_BITS      = 5;
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [0:0] REG_RING_SIZE_LOG2 = 1'b0;

    localparam logic [1:0] STATUS_WORD     = 2'd0;
    localparam logic [1:0] STATUS_NO_SPACE = 2'd1;
    localparam logic [1:0] STATUS_BAD_LEN  = 2'd2;
    localparam logic [1:0] STATUS_PTR      = 2'd3;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_WRITE,
        MODE_DISCARD,
        MODE_FILL
    } frame_mode_t;

    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_REL,
        SEQ_USED,
        SEQ_FREE,
        SEQ_DISPATCH,
        SEQ_CHECK,
        SEQ_HDR,
        SEQ_BYTE,
        SEQ_FILL,
        SEQ_END
    } seq_state_t;

    typedef struct packed {
        logic [PTR_BITS-1:0] a;
        logic [PTR_BITS-1:0] b;
        logic                sub;
    } alu_req_t;

    typedef struct packed {
        logic [PTR_BITS-1:0] sum;
        logic                borrow;
    } alu_rsp_t;

    function automatic logic [PTR_BITS-1:0] ring_mask(input logic [LOG2_BITS-1:0] lg);
        logic [LOG2_BITS:0]  l;
        logic [PTR_BITS-1:0] m;
        l = {1'b0, lg};
        if (l < (LOG2_BITS+1)'(LOG2_MIN)) begin
            l = (LOG2_BITS+1)'(LOG2_MIN);
        end
        if (l > (LOG2_BITS+1)'(PTR_BITS)) begin
            l = (LOG2_BITS+1)'(PTR_BITS);
        end
        for (int i = 0; i < PTR_BITS; i++) begin
            m[i] = ((LOG2_BITS+1)'(i) < l);
        end
        return m;
    endfunction

    function automatic logic [LEN_BITS-1:0] frame_pad_len(input logic [LEN_BITS-1:0] len);
        return (len < LEN_BITS'(MIN_FRAME)) ? LEN_BITS'(MIN_FRAME) : len;
    endfunction

    function automatic logic [ALEN_BITS-1:0] aligned_len(input logic [LEN_BITS-1:0] len);
        logic [ALEN_BITS-1:0] s;
        s = {1'b0, frame_pad_len(len)} + ALEN_BITS'(3);
        return {s[ALEN_BITS-1:2], 2'b00};
    endfunction

endpackage

// ===== hw/rtl/trfw_alu.sv =====
// Shared add/subtract unit of the transmit ring frame writer.
// One adder serves pointer advance, space and compare steps.
// Depends on trfw_pkg.
module trfw_alu (
    input  trfw_pkg::alu_req_t req,
    output trfw_pkg::alu_rsp_t rsp
);
    import trfw_pkg::*;

    logic [PTR_BITS:0] res;

    always_comb
    begin
        res = {1'b0, req.a} + {1'b0, req.b ^ {PTR_BITS{req.sub}}} + (PTR_BITS+1)'(req.sub);
        rsp.sum    = res[PTR_BITS-1:0];
        rsp.borrow = req.sub & ~res[PTR_BITS];
    end

endmodule

// ===== hw/rtl/trfw_seq.sv =====
// Sequencer and datapath state of the transmit ring frame writer.
// Steps each input item through the shared unit and holds the result register.
// Depends on trfw_pkg and trfw_alu.
module trfw_seq (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [trfw_pkg::PTR_BITS-1:0]      mask,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               kind,
    input  logic [7:0]                         data_byte,
    input  logic [trfw_pkg::LEN_BITS-1:0]      frame_len,
    input  logic                               last_byte,
    input  logic [trfw_pkg::PTR_BITS-1:0]      consumer_ptr,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [1:0]                         status,
    output logic [trfw_pkg::PTR_BITS-1:0]      write_addr,
    output logic [31:0]                        write_data,
    output logic [trfw_pkg::PTR_BITS-1:0]      end_ptr,
    output logic [trfw_pkg::PTR_BITS-1:0]      space_left,
    output logic                               last_of_run
);
    import trfw_pkg::*;

    seq_state_t           state_reg, state_next;
    frame_mode_t          mode_reg, mode_next;
    logic                 fill_idle_reg, fill_idle_next;
    logic                 commit_reg, commit_next;

    logic                 kind_reg, kind_next;
    logic [7:0]           byte_reg, byte_next;
    logic [LEN_BITS-1:0]  len_reg, len_next;
    logic                 last_reg, last_next;
    logic [PTR_BITS-1:0]  cptr_reg, cptr_next;

    logic [PTR_BITS-1:0]  producer_reg, producer_next;
    logic [PTR_BITS-1:0]  release_reg, release_next;
    logic [PTR_BITS-1:0]  write_ptr_reg, write_ptr_next;
    logic [PTR_BITS-1:0]  used_reg, used_next;
    logic [PTR_BITS-1:0]  free_reg, free_next;
    logic [31:0]          accum_reg, accum_next;
    logic [LEN_BITS-1:0]  bi_reg, bi_next;
    logic [LEN_BITS-1:0]  cur_len_reg, cur_len_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;

    logic                 pend_valid_reg, pend_valid_next;
    logic [1:0]           pend_status_reg, pend_status_next;
    logic [PTR_BITS-1:0]  pend_addr_reg, pend_addr_next;
    logic [31:0]          pend_data_reg, pend_data_next;

    logic                 out_valid_reg, out_valid_next;
    logic [1:0]           out_status_reg, out_status_next;
    logic [PTR_BITS-1:0]  out_addr_reg, out_addr_next;
    logic [31:0]          out_data_reg, out_data_next;
    logic [PTR_BITS-1:0]  out_end_reg, out_end_next;
    logic [PTR_BITS-1:0]  out_free_reg, out_free_next;
    logic                 out_last_reg, out_last_next;

    alu_req_t             alu_req;
    alu_rsp_t             alu_rsp;

    logic                 out_room;
    logic                 move_ok;
    logic                 emit;
    logic                 flush;
    logic [1:0]           emit_status;
    logic [PTR_BITS-1:0]  emit_addr;
    logic [31:0]          emit_data;
    logic [1:0]           lane;
    logic [31:0]          merged;
    logic [LEN_BITS-1:0]  bi_word;
    logic [LEN_BITS-1:0]  bi_new;
    logic                 proceed;
    logic [ALEN_BITS-1:0] target;
    logic [ALEN_BITS-1:0] need;
    logic [PTR_BITS-1:0]  wp0;

    trfw_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= SEQ_IDLE;
            mode_reg       <= MODE_IDLE;
            fill_idle_reg  <= 1'b0;
            commit_reg     <= 1'b0;
            producer_reg   <= '0;
            release_reg    <= '0;
            write_ptr_reg  <= '0;
            used_reg       <= '0;
            free_reg       <= '0;
            accum_reg      <= '0;
            bi_reg         <= '0;
            cur_len_reg    <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            fill_idle_reg  <= fill_idle_next;
            commit_reg     <= commit_next;
            producer_reg   <= producer_next;
            release_reg    <= release_next;
            write_ptr_reg  <= write_ptr_next;
            used_reg       <= used_next;
            free_reg       <= free_next;
            accum_reg      <= accum_next;
            bi_reg         <= bi_next;
            cur_len_reg    <= cur_len_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg        <= kind_next;
        byte_reg        <= byte_next;
        len_reg         <= len_next;
        last_reg        <= last_next;
        cptr_reg        <= cptr_next;
        pend_status_reg <= pend_status_next;
        pend_addr_reg   <= pend_addr_next;
        pend_data_reg   <= pend_data_next;
        out_status_reg  <= out_status_next;
        out_addr_reg    <= out_addr_next;
        out_data_reg    <= out_data_next;
        out_end_reg     <= out_end_next;
        out_free_reg    <= out_free_next;
        out_last_reg    <= out_last_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        mode_next        = mode_reg;
        fill_idle_next   = fill_idle_reg;
        commit_next      = commit_reg;
        kind_next        = kind_reg;
        byte_next        = byte_reg;
        len_next         = len_reg;
        last_next        = last_reg;
        cptr_next        = cptr_reg;
        producer_next    = producer_reg;
        release_next     = release_reg;
        write_ptr_next   = write_ptr_reg;
        used_next        = used_reg;
        free_next        = free_reg;
        accum_next       = accum_reg;
        bi_next          = bi_reg;
        cur_len_next     = cur_len_reg;
        cnt_next         = cnt_reg;
        pend_valid_next  = pend_valid_reg;
        pend_status_next = pend_status_reg;
        pend_addr_next   = pend_addr_reg;
        pend_data_next   = pend_data_reg;
        out_valid_next   = out_valid_reg;
        out_status_next  = out_status_reg;
        out_addr_next    = out_addr_reg;
        out_data_next    = out_data_reg;
        out_end_next     = out_end_reg;
        out_free_next    = out_free_reg;
        out_last_next    = out_last_reg;

        alu_req.a   = '0;
        alu_req.b   = '0;
        alu_req.sub = 1'b0;

        out_room    = !out_valid_reg || !out_stall;
        move_ok     = !pend_valid_reg || out_room;
        emit        = 1'b0;
        flush       = 1'b0;
        emit_status = STATUS_WORD;
        emit_addr   = '0;
        emit_data   = '0;
        lane        = bi_reg[1:0];
        merged      = accum_reg | (32'(byte_reg) << {lane, 3'b000});
        bi_word     = {bi_reg[LEN_BITS-1:2], 2'b00} + LEN_BITS'(4);
        bi_new      = bi_reg;
        proceed     = 1'b1;
        target      = aligned_len(cur_len_reg);
        need        = aligned_len(len_reg) + ALEN_BITS'(4);
        wp0         = producer_reg & mask;
        in_stall    = (state_reg != SEQ_IDLE);

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            SEQ_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next   = kind;
                    byte_next   = data_byte;
                    len_next    = frame_len;
                    last_next   = last_byte;
                    cptr_next   = consumer_ptr;
                    cnt_next    = '0;
                    commit_next = 1'b0;
                    state_next  = kind ? SEQ_REL : SEQ_USED;
                end
            end
            SEQ_REL:
            begin
                release_next = {cptr_reg[PTR_BITS-1:2] & mask[PTR_BITS-1:2], 2'b00};
                state_next   = SEQ_USED;
            end
            SEQ_USED:
            begin
                alu_req.a   = producer_reg;
                alu_req.b   = release_reg;
                alu_req.sub = 1'b1;
                used_next   = alu_rsp.sum & mask;
                state_next  = SEQ_FREE;
            end
            SEQ_FREE:
            begin
                alu_req.a   = {mask[PTR_BITS-1:2], 2'b00};
                alu_req.b   = used_reg;
                alu_req.sub = 1'b1;
                free_next   = alu_rsp.sum;
                state_next  = commit_reg ? SEQ_END : SEQ_DISPATCH;
            end
            SEQ_DISPATCH:
            begin
                state_next = SEQ_END;
                if (kind_reg)
                begin
                    emit        = 1'b1;
                    emit_status = STATUS_PTR;
                end
                else
                begin
                    case (mode_reg)
                        MODE_DISCARD:
                        begin
                            if (last_reg)
                            begin
                                mode_next = MODE_IDLE;
                            end
                        end
                        MODE_FILL:
                        begin
                            state_next = SEQ_FILL;
                        end
                        MODE_WRITE:
                        begin
                            state_next = SEQ_BYTE;
                        end
                        MODE_IDLE:
                        begin
                            if (len_reg == '0 || len_reg > LEN_BITS'(MAX_FRAME))
                            begin
                                emit        = 1'b1;
                                emit_status = STATUS_BAD_LEN;
                                mode_next   = last_reg ? MODE_IDLE : MODE_DISCARD;
                            end
                            else
                            begin
                                state_next = SEQ_CHECK;
                            end
                        end
                        default:
                        begin
                            state_next = SEQ_END;
                        end
                    endcase
                end
            end
            SEQ_CHECK:
            begin
                alu_req.a   = free_reg;
                alu_req.b   = PTR_BITS'(need);
                alu_req.sub = 1'b1;
                if (alu_rsp.borrow)
                begin
                    emit        = 1'b1;
                    emit_status = STATUS_NO_SPACE;
                    mode_next   = last_reg ? MODE_IDLE : MODE_DISCARD;
                    state_next  = SEQ_END;
                end
                else
                begin
                    state_next = SEQ_HDR;
                end
            end
            SEQ_HDR:
            begin
                alu_req.a      = wp0;
                alu_req.b      = PTR_BITS'(4);
                emit           = 1'b1;
                emit_status    = STATUS_WORD;
                emit_addr      = wp0;
                emit_data      = 32'(frame_pad_len(len_reg));
                write_ptr_next = alu_rsp.sum & mask;
                cur_len_next   = len_reg;
                accum_next     = '0;
                bi_next        = '0;
                cnt_next       = cnt_reg + CNT_BITS'(1);
                mode_next      = MODE_WRITE;
                state_next     = SEQ_BYTE;
            end
            SEQ_BYTE:
            begin
                if (bi_reg < cur_len_reg)
                begin
                    if (lane == 2'd3)
                    begin
                        if (move_ok)
                        begin
                            alu_req.a      = write_ptr_reg;
                            alu_req.b      = PTR_BITS'(4);
                            emit           = 1'b1;
                            emit_status    = STATUS_WORD;
                            emit_addr      = write_ptr_reg;
                            emit_data      = merged;
                            write_ptr_next = alu_rsp.sum & mask;
                            accum_next     = '0;
                            bi_new         = bi_word;
                            cnt_next       = cnt_reg + CNT_BITS'(1);
                        end
                        else
                        begin
                            proceed = 1'b0;
                        end
                    end
                    else
                    begin
                        accum_next = merged;
                        bi_new     = bi_reg + LEN_BITS'(1);
                    end
                end
                if (proceed)
                begin
                    bi_next = bi_new;
                    if (bi_new >= cur_len_reg || last_reg)
                    begin
                        fill_idle_next = last_reg;
                        state_next     = SEQ_FILL;
                    end
                    else
                    begin
                        state_next = SEQ_END;
                    end
                end
            end
            SEQ_FILL:
            begin
                if ({1'b0, bi_reg} < target)
                begin
                    if (cnt_reg < CNT_BITS'(RESULT_LIMIT))
                    begin
                        if (move_ok)
                        begin
                            alu_req.a      = write_ptr_reg;
                            alu_req.b      = PTR_BITS'(4);
                            emit           = 1'b1;
                            emit_status    = STATUS_WORD;
                            emit_addr      = write_ptr_reg;
                            emit_data      = accum_reg;
                            write_ptr_next = alu_rsp.sum & mask;
                            accum_next     = '0;
                            bi_next        = bi_word;
                            cnt_next       = cnt_reg + CNT_BITS'(1);
                        end
                    end
                    else
                    begin
                        mode_next  = MODE_FILL;
                        state_next = SEQ_END;
                    end
                end
                else
                begin
                    producer_next = write_ptr_reg;
                    mode_next     = fill_idle_reg ? MODE_IDLE : MODE_DISCARD;
                    commit_next   = 1'b1;
                    state_next    = SEQ_USED;
                end
            end
            SEQ_END:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = SEQ_IDLE;
                end
                else if (out_room)
                begin
                    flush      = 1'b1;
                    state_next = SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase

        if ((emit || flush) && pend_valid_reg)
        begin
            out_valid_next  = 1'b1;
            out_status_next = pend_status_reg;
            out_addr_next   = pend_addr_reg;
            out_data_next   = pend_data_reg;
            out_end_next    = producer_reg;
            out_free_next   = free_reg;
            out_last_next   = flush;
            pend_valid_next = 1'b0;
        end
        if (emit)
        begin
            pend_valid_next  = 1'b1;
            pend_status_next = emit_status;
            pend_addr_next   = emit_addr;
            pend_data_next   = emit_data;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign write_addr  = out_addr_reg;
    assign write_data  = out_data_reg;
    assign end_ptr     = out_end_reg;
    assign space_left  = out_free_reg;
    assign last_of_run = out_last_reg;

endmodule

// ===== hw/rtl/tx_ring_frame_writer.sv =====
// Each item steps through the sequencer states: release (pointer items only), used, free,
// dispatch, then check, header, byte or fill as the frame mode needs, and end; a commit
// repeats used and free. A new item is taken only in idle, as the sequencer steps every
// add, subtract and compare through one shared adder; a stall on the output adds to this.
// Reset: pointers, word buffer and counts clear, frame mode goes idle,
// ring_size_log2 returns to 11.
// Top level: configuration register and the frame writer sequencer.
// Depends on trfw_pkg and trfw_seq.
module tx_ring_frame_writer (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [trfw_pkg::CFG_ADDR_BITS-1:0]    paddr,
    input  logic [trfw_pkg::CFG_DATA_BITS-1:0]    pwdata,
    output logic [trfw_pkg::CFG_DATA_BITS-1:0]    prdata,
    output logic                                  pready,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  kind,
    input  logic [7:0]                            data_byte,
    input  logic [trfw_pkg::LEN_BITS-1:0]         frame_len,
    input  logic                                  last_byte,
    input  logic [trfw_pkg::PTR_BITS-1:0]         consumer_ptr,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [1:0]                            status,
    output logic [trfw_pkg::PTR_BITS-1:0]         write_addr,
    output logic [31:0]                           write_data,
    output logic [trfw_pkg::PTR_BITS-1:0]         end_ptr,
    output logic [trfw_pkg::PTR_BITS-1:0]         space_left,
    output logic                                  last_of_run
);
    import trfw_pkg::*;

    logic [LOG2_BITS-1:0] ring_log2_reg, ring_log2_next;
    logic                 reg_hit;
    logic [PTR_BITS-1:0]  mask;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[CFG_ADDR_BITS-1:2] == REG_RING_SIZE_LOG2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_log2_reg <= LOG2_BITS'(LOG2_MIN);
        end
        else
        begin
            ring_log2_reg <= ring_log2_next;
        end
    end

    always_comb
    begin
        ring_log2_next = ring_log2_reg;
        if (psel && penable && pwrite && pready && reg_hit)
        begin
            ring_log2_next = pwdata[LOG2_BITS-1:0];
        end
        prdata = reg_hit ? CFG_DATA_BITS'(ring_log2_reg) : '0;
        mask   = ring_mask(ring_log2_reg);
    end

    trfw_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .mask         (mask),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .data_byte    (data_byte),
        .frame_len    (frame_len),
        .last_byte    (last_byte),
        .consumer_ptr (consumer_ptr),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .write_addr   (write_addr),
        .write_data   (write_data),
        .end_ptr      (end_ptr),
        .space_left   (space_left),
        .last_of_run  (last_of_run)
    );

endmodule
